// ===== rtl/core/bpt_pkg.sv =====
package bpt_pkg;

  localparam int unsigned CFG_W      = 32;
  localparam int unsigned TIME_W     = 64;
  localparam int unsigned CHARGE_W   = 32;
  localparam int unsigned COUNT_W    = 32;
  localparam int unsigned PCT_W      = 7;
  localparam int unsigned PROD_W     = CFG_W + PCT_W + 1;

  localparam logic [CFG_W-1:0] MIN_PERIOD_NS_DEF = 32'd1000000;
  localparam logic [CFG_W-1:0] MAX_PERIOD_NS_DEF = 32'd1000000000;
  localparam logic [PCT_W-1:0] MIN_QUOTA_PCT_DEF = 7'd1;
  localparam logic [PCT_W-1:0] PCT_SCALE         = 7'd100;

  localparam logic [CFG_W-1:0] PERIOD_RESET = 32'd1000000000;
  localparam logic [CFG_W-1:0] QUOTA_RESET  = 32'd1000000000;

  typedef enum logic [1:0] {
    MODE_START  = 2'd0,
    MODE_CHARGE = 2'd1,
    MODE_CHECK  = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef enum logic {
    REG_PERIOD = 1'b0,
    REG_QUOTA  = 1'b1
  } reg_index_t;

endpackage

// ===== rtl/core/bandwidth_period_throttle_top.sv =====
// Period and quota bandwidth limiter. Each request carries a mode (start,
// charge, check or none), a time stamp and a runtime charge, and gives one
// result: start status, whether period runtime is below the quota, the
// throttle flag, the total charged runtime and the count of throttle events.
// A request is registered on entry, its result in an output register; one
// request is taken every cycle while the output is not stalled. The state
// update (rollover compare, three 64-bit adds, quota compare) fits between
// the entry and state registers. Input stall rises only when both registers
// are full and the output is stalled. period_ns and quota_ns are read live;
// the user must write them only while idle (the block does not enforce it).
module bandwidth_period_throttle_top #(
  parameter logic [bpt_pkg::CFG_W-1:0] MIN_PERIOD_NS = bpt_pkg::MIN_PERIOD_NS_DEF,
  parameter logic [bpt_pkg::CFG_W-1:0] MAX_PERIOD_NS = bpt_pkg::MAX_PERIOD_NS_DEF,
  parameter logic [bpt_pkg::PCT_W-1:0] MIN_QUOTA_PCT = bpt_pkg::MIN_QUOTA_PCT_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [bpt_pkg::CFG_W-1:0]    cfg_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   mode,
  input  logic [bpt_pkg::TIME_W-1:0]   now_ns,
  input  logic [bpt_pkg::CHARGE_W-1:0] charge_ns,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         status,
  output logic                         under_quota,
  output logic                         throttled,
  output logic [bpt_pkg::TIME_W-1:0]   run_total,
  output logic [bpt_pkg::COUNT_W-1:0]  throttle_count
);
  import bpt_pkg::*;

  logic [CFG_W-1:0]    period_ns;
  logic [CFG_W-1:0]    quota_ns;

  logic                item_full;
  mode_t               item_mode;
  logic [TIME_W-1:0]   item_now;
  logic [CHARGE_W-1:0] item_charge;

  logic [TIME_W-1:0]   period_runtime, period_runtime_next;
  logic [TIME_W-1:0]   deadline, deadline_next;
  logic                throttle_flag, throttle_flag_next;
  logic [TIME_W-1:0]   runtime_sum, runtime_sum_next;
  logic [COUNT_W-1:0]  throttle_events, throttle_events_next;
  logic                status_next;

  logic                in_take;
  logic                advance;
  logic                regs_ok;
  logic [PROD_W-1:0]   pct_prod;
  logic [PROD_W-1:0]   quota_scaled;
  logic                roll;
  logic [TIME_W:0]     dl_sum;
  logic [TIME_W-1:0]   dl_new;
  logic [TIME_W-1:0]   base_rt;
  logic [TIME_W:0]     rt_sum;
  logic [TIME_W:0]     tot_sum;
  logic [TIME_W-1:0]   rt_new;
  logic [TIME_W-1:0]   tot_new;

  assign advance  = item_full && (!out_valid || !out_stall);
  assign in_stall = item_full && out_valid && out_stall;
  assign in_take  = in_valid && !in_stall;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      period_ns <= PERIOD_RESET;
      quota_ns  <= QUOTA_RESET;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_PERIOD: period_ns <= cfg_data;
        REG_QUOTA:  quota_ns  <= cfg_data;
        default:    ;
      endcase
    end
  end

  // entry register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_full <= 1'b0;
    end else if (in_take) begin
      item_full <= 1'b1;
    end else if (advance) begin
      item_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_mode   <= mode_t'(mode);
      item_now    <= now_ns;
      item_charge <= charge_ns;
    end
  end

  // quota < floor(period * pct / 100) is the same as 100 * quota + 100 <= period * pct
  assign pct_prod     = PROD_W'(period_ns) * PROD_W'(MIN_QUOTA_PCT);
  assign quota_scaled = PROD_W'(quota_ns) * PROD_W'(PCT_SCALE) + PROD_W'(PCT_SCALE);
  assign regs_ok = (period_ns >= MIN_PERIOD_NS) && (period_ns <= MAX_PERIOD_NS) &&
                   (quota_ns <= period_ns) && (quota_scaled > pct_prod);

  assign roll    = item_now >= deadline;
  assign dl_sum  = {1'b0, item_now} + {{(TIME_W+1-CFG_W){1'b0}}, period_ns};
  assign dl_new  = dl_sum[TIME_W] ? {TIME_W{1'b1}} : dl_sum[TIME_W-1:0];
  assign base_rt = roll ? '0 : period_runtime;
  assign rt_sum  = {1'b0, base_rt} + {{(TIME_W+1-CHARGE_W){1'b0}}, item_charge};
  assign rt_new  = rt_sum[TIME_W] ? {TIME_W{1'b1}} : rt_sum[TIME_W-1:0];
  assign tot_sum = {1'b0, runtime_sum} + {{(TIME_W+1-CHARGE_W){1'b0}}, item_charge};
  assign tot_new = tot_sum[TIME_W] ? {TIME_W{1'b1}} : tot_sum[TIME_W-1:0];

  always_comb begin
    period_runtime_next  = period_runtime;
    deadline_next        = deadline;
    throttle_flag_next   = throttle_flag;
    runtime_sum_next     = runtime_sum;
    throttle_events_next = throttle_events;
    status_next          = 1'b0;
    case (item_mode)
      MODE_START: begin
        if (regs_ok) begin
          period_runtime_next  = '0;
          deadline_next        = dl_new;
          throttle_flag_next   = 1'b0;
          runtime_sum_next     = '0;
          throttle_events_next = '0;
        end else begin
          status_next = 1'b1;
        end
      end
      MODE_CHARGE: begin
        period_runtime_next = rt_new;
        runtime_sum_next    = tot_new;
        if (roll) begin
          deadline_next = dl_new;
        end
        throttle_flag_next = throttle_flag && !roll;
        // first overrun in this period raises the flag and counts an event
        if ((rt_new > TIME_W'(quota_ns)) && !throttle_flag_next) begin
          throttle_flag_next = 1'b1;
          if (throttle_events != {COUNT_W{1'b1}}) begin
            throttle_events_next = throttle_events + COUNT_W'(1);
          end
        end
      end
      MODE_CHECK: begin
        if (roll) begin
          period_runtime_next = '0;
          deadline_next       = dl_new;
          throttle_flag_next  = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      period_runtime  <= '0;
      deadline        <= '0;
      throttle_flag   <= 1'b0;
      runtime_sum     <= '0;
      throttle_events <= '0;
    end else if (advance) begin
      period_runtime  <= period_runtime_next;
      deadline        <= deadline_next;
      throttle_flag   <= throttle_flag_next;
      runtime_sum     <= runtime_sum_next;
      throttle_events <= throttle_events_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      status         <= status_next;
      under_quota    <= period_runtime_next < TIME_W'(quota_ns);
      throttled      <= throttle_flag_next;
      run_total      <= runtime_sum_next;
      throttle_count <= throttle_events_next;
    end
  end

endmodule

// ===== rtl/core/bpt_checker.sv =====
module bpt_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic                         status,
  input logic                         under_quota,
  input logic                         throttled,
  input logic [bpt_pkg::TIME_W-1:0]   run_total,
  input logic [bpt_pkg::COUNT_W-1:0]  throttle_count
);

  // nothing is left over in the result register after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // the input side only backs up when the result side is full and stalled
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while result side can move");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("stalled result dropped");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> ($stable(run_total) && $stable(throttle_count) &&
                                  $stable(status) && $stable(throttled) &&
                                  $stable(under_quota)))
    else $error("stalled result changed");

endmodule

bind bandwidth_period_throttle_top bpt_checker u_bpt_checker (.*);
